>>> sv/sorb_pkg.sv
// sorb_pkg: shared types, register codes and the sine table generator
// for the sensor orientation / board rotation block. No dependencies.
package sorb_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int ANGLE_W   = 10;
    localparam int ORIENT_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIENT = 2'd0,
        CFG_ROLL   = 2'd1,
        CFG_PITCH  = 2'd2,
        CFG_YAW    = 2'd3
    } cfg_index_t;

    // fixed sensor mounting orientations
    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_CW0       = 3'd0,
        ORIENT_CW90      = 3'd1,
        ORIENT_CW180     = 3'd2,
        ORIENT_CW270     = 3'd3,
        ORIENT_FLIP_CW0   = 3'd4,
        ORIENT_FLIP_CW90  = 3'd5,
        ORIENT_FLIP_CW180 = 3'd6,
        ORIENT_FLIP_CW270 = 3'd7
    } orient_t;

    localparam longint unsigned Q30_PI = 64'd3373259426;

    function automatic longint unsigned mul_q30(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // sin(k degrees) in Q30 by integer Taylor series, k = 0..90
    // term n is divided by (2n)(2n+1)
    function automatic longint unsigned sine_q30(input int k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (longint'(k) * Q30_PI + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = mul_q30(mul_q30(term, x), x);
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                default: term = term / 64'd600;   // last term, n = 12
            endcase
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) <<< 30))
            sum = longint'(1) <<< 30;
        return longint'(sum);
    endfunction

endpackage

>>> sv/sorb_sample_if.sv
// sorb_sample_if, sorb_aligned_if, sorb_cfg_if: valid/ready channels of the block
// depends on sorb_pkg for the configuration port widths
interface sorb_sample_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface sorb_aligned_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] aligned_x;
    logic signed [SAMPLE_BITS-1:0] aligned_y;
    logic signed [SAMPLE_BITS-1:0] aligned_z;

    modport source (output valid, output aligned_x, output aligned_y, output aligned_z,
                    input ready);
    modport sink   (input valid, input aligned_x, input aligned_y, input aligned_z,
                    output ready);
endinterface

interface sorb_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [sorb_pkg::CFG_IDX_W-1:0]   index;
    logic [sorb_pkg::ANGLE_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/sensor_orientation_board_rotation_top.sv
// sensor_orientation_board_rotation_top: axis remap plus board rotation pipeline
// depends on sorb_pkg and the channel interfaces in sorb_sample_if.sv
//
// One sample beat is taken per clock and its aligned beat is registered through
// the remap, nine products, column sums, rounding and saturation steps, so the
// sustained rate is one beat per cycle as long as the aligned side keeps ready
// high; a stall on the aligned side freezes the whole data pipeline at once
// and sample.ready drops in the same cycle. The rotation matrix is not built
// per beat: a four-stage coefficient pipeline (sine/cosine lookup, coefficient
// products, cross products with sin(pitch), sums) recomputes it from the angle
// registers, so after reset and after every configuration write sample.ready
// stays low while the matrix settles. Configuration writes are always taken
// (cfg.ready is tied high) and should come only while no beat is in flight.
// With all three angles zero the rotation is bypassed and the remapped sample
// is only saturated.
module sensor_orientation_board_rotation_top #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    sorb_sample_if.sink    sample,
    sorb_aligned_if.source aligned,
    sorb_cfg_if.sink       cfg
);
    import sorb_pkg::*;

    // coefficient and data path widths
    localparam int CF = COEF_FRAC_BITS;
    localparam int CW = CF + 2;              // sin/cos and coefficient products
    localparam int MW = CF + 3;              // matrix entries, sums of two terms
    localparam int VW = SAMPLE_BITS + 1;     // remapped sample, exact negation
    localparam int PW = MW + VW;             // entry times sample
    localparam int AW = PW + 2;              // column sum of three products
    localparam int SETTLE = 4;               // coefficient pipeline depth
    localparam int SW = $clog2(SETTLE + 1);

    localparam logic signed [2*CW-1:0] C_HALF  = (2*CW)'(longint'(1) <<< (CF - 1));
    localparam logic signed [AW-1:0]   A_HALF  = AW'(longint'(1) <<< (CF - 1));
    localparam logic signed [AW-1:0]   SAT_HI  =
        AW'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
    localparam logic signed [AW-1:0]   SAT_LO  = -SAT_HI - AW'(1);

    // sine table, 0..90 degrees, unsigned q(CF)
    typedef logic [CF:0] sin_tab_t [0:90];

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t        t;
        longint unsigned s;
        for (int k = 0; k <= 90; k++) begin
            s    = sine_q30(k);
            t[k] = (CF+1)'((s + (64'd1 << (30 - CF - 1))) >> (30 - CF));
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // angle reduced into 0..359
    function automatic logic [8:0] reduce_deg(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W+1:0] t;
        t = a;
        if (a < 0)
            t = t + 12'sd720;
        if (t >= 12'sd360)
            t = t - 12'sd360;
        return t[8:0];
    endfunction

    // cosine as sine of the angle moved by a quarter turn
    function automatic logic [8:0] quarter_deg(input logic [8:0] r);
        logic [9:0] c;
        c = {1'b0, r} + 10'd90;
        if (c >= 10'd360)
            c = c - 10'd360;
        return c[8:0];
    endfunction

    // quadrant symmetry around the table
    function automatic logic signed [CW-1:0] sin_lookup(input logic [8:0] r);
        logic [6:0]             idx;
        logic                   neg;
        logic signed [CW-1:0]   mag;
        if (r <= 9'd90) begin
            idx = r[6:0];
            neg = 1'b0;
        end else if (r <= 9'd180) begin
            idx = 7'(9'd180 - r);
            neg = 1'b0;
        end else if (r <= 9'd270) begin
            idx = 7'(r - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(9'd360 - r);
            neg = 1'b1;
        end
        mag = CW'(SIN_TAB[idx]);
        return neg ? -mag : mag;
    endfunction

    // coefficient product, rounded half away from zero
    function automatic logic signed [CW-1:0] cmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        logic signed [2*CW-1:0] r;
        p = a * b;
        r = (p + (p[2*CW-1] ? C_HALF - (2*CW)'(1) : C_HALF)) >>> CF;
        return r[CW-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [AW-1:0] a);
        if (a > SAT_HI)
            return SAT_HI[SAMPLE_BITS-1:0];
        if (a < SAT_LO)
            return SAT_LO[SAMPLE_BITS-1:0];
        return a[SAMPLE_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // configuration registers and settle counter
    // ---------------------------------------------------------------------
    logic [ORIENT_W-1:0]       orient_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic [SW-1:0]             settle_reg;
    logic                      cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= '0;
            roll_reg   <= '0;
            pitch_reg  <= '0;
            yaw_reg    <= '0;
            settle_reg <= SW'(SETTLE);
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg.index)
                    CFG_ORIENT: orient_reg <= cfg.data[ORIENT_W-1:0];
                    CFG_ROLL:   roll_reg   <= cfg.data;
                    CFG_PITCH:  pitch_reg  <= cfg.data;
                    CFG_YAW:    yaw_reg    <= cfg.data;
                    default:    ;
                endcase
                settle_reg <= SW'(SETTLE);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SW'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // coefficient pipeline: matrix follows the angle registers
    // ---------------------------------------------------------------------
    // c1: sine and cosine of each angle
    logic signed [CW-1:0] cx_reg, sx_reg, cy_reg, sy_reg, cz_reg, sz_reg;
    logic                 ang_zero_reg;
    // c2: first-level products
    logic signed [CW-1:0] zx_cc_reg, zx_sc_reg, zx_cs_reg, zx_ss_reg;
    logic signed [CW-1:0] m00_c2_reg, m01_c2_reg, m12_c2_reg, m22_c2_reg, sy_c2_reg;
    // c3: products with sin(pitch)
    logic signed [CW-1:0] p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [CW-1:0] zx_cc_c3_reg, zx_sc_c3_reg, zx_cs_c3_reg, zx_ss_c3_reg;
    logic signed [CW-1:0] m00_c3_reg, m01_c3_reg, m12_c3_reg, m22_c3_reg, sy_c3_reg;
    // c4: matrix, m_reg[row][col]
    logic signed [MW-1:0] m_reg [3][3];

    logic [8:0] roll_r, pitch_r, yaw_r;

    always_comb
    begin
        roll_r  = reduce_deg(roll_reg);
        pitch_r = reduce_deg(pitch_reg);
        yaw_r   = reduce_deg(yaw_reg);
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= sin_lookup(quarter_deg(roll_r));
        sx_reg       <= sin_lookup(roll_r);
        cy_reg       <= sin_lookup(quarter_deg(pitch_r));
        sy_reg       <= sin_lookup(pitch_r);
        cz_reg       <= sin_lookup(quarter_deg(yaw_r));
        sz_reg       <= sin_lookup(yaw_r);
        ang_zero_reg <= (roll_reg == '0) && (pitch_reg == '0) && (yaw_reg == '0);

        zx_cc_reg  <= cmul(cz_reg, cx_reg);
        zx_sc_reg  <= cmul(sz_reg, cx_reg);
        zx_cs_reg  <= cmul(cz_reg, sx_reg);
        zx_ss_reg  <= cmul(sz_reg, sx_reg);
        m00_c2_reg <= cmul(cz_reg, cy_reg);
        m01_c2_reg <= -cmul(cy_reg, sz_reg);
        m12_c2_reg <= -cmul(sx_reg, cy_reg);
        m22_c2_reg <= cmul(cy_reg, cx_reg);
        sy_c2_reg  <= sy_reg;

        p10_reg      <= cmul(zx_cs_reg, sy_c2_reg);
        p11_reg      <= cmul(zx_ss_reg, sy_c2_reg);
        p20_reg      <= cmul(zx_cc_reg, sy_c2_reg);
        p21_reg      <= cmul(zx_sc_reg, sy_c2_reg);
        zx_cc_c3_reg <= zx_cc_reg;
        zx_sc_c3_reg <= zx_sc_reg;
        zx_cs_c3_reg <= zx_cs_reg;
        zx_ss_c3_reg <= zx_ss_reg;
        m00_c3_reg   <= m00_c2_reg;
        m01_c3_reg   <= m01_c2_reg;
        m12_c3_reg   <= m12_c2_reg;
        m22_c3_reg   <= m22_c2_reg;
        sy_c3_reg    <= sy_c2_reg;

        m_reg[0][0] <= MW'(m00_c3_reg);
        m_reg[0][1] <= MW'(m01_c3_reg);
        m_reg[0][2] <= MW'(sy_c3_reg);
        m_reg[1][0] <= MW'(zx_sc_c3_reg) + MW'(p10_reg);
        m_reg[1][1] <= MW'(zx_cc_c3_reg) - MW'(p11_reg);
        m_reg[1][2] <= MW'(m12_c3_reg);
        m_reg[2][0] <= MW'(zx_ss_c3_reg) - MW'(p20_reg);
        m_reg[2][1] <= MW'(zx_cs_c3_reg) + MW'(p21_reg);
        m_reg[2][2] <= MW'(m22_c3_reg);
    end

    // ---------------------------------------------------------------------
    // data pipeline, one global enable
    // ---------------------------------------------------------------------
    logic en;
    logic in_acc;
    logic d1_valid_reg, d2_valid_reg, d3_valid_reg, d4_valid_reg, out_valid_reg;

    assign en           = !out_valid_reg || aligned.ready;
    assign sample.ready = en && (settle_reg == '0);
    assign in_acc       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg  <= 1'b0;
            d2_valid_reg  <= 1'b0;
            d3_valid_reg  <= 1'b0;
            d4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d1_valid_reg  <= in_acc;
            d2_valid_reg  <= d1_valid_reg;
            d3_valid_reg  <= d2_valid_reg;
            d4_valid_reg  <= d3_valid_reg;
            out_valid_reg <= d4_valid_reg;
        end
    end

    // d1: axis swap and sign flip, exact at one extra bit
    logic signed [VW-1:0] sx, sy, sz;
    logic signed [VW-1:0] v_next [3];
    logic signed [VW-1:0] v1_reg [3];
    logic signed [VW-1:0] v2_reg [3];
    logic signed [VW-1:0] v3_reg [3];
    logic signed [VW-1:0] v4_reg [3];

    always_comb
    begin
        sx = sample.sample_x;
        sy = sample.sample_y;
        sz = sample.sample_z;
        case (orient_reg)
            ORIENT_CW90:       begin v_next[0] = sy;  v_next[1] = -sx; v_next[2] = sz;  end
            ORIENT_CW180:      begin v_next[0] = -sx; v_next[1] = -sy; v_next[2] = sz;  end
            ORIENT_CW270:      begin v_next[0] = -sy; v_next[1] = sx;  v_next[2] = sz;  end
            ORIENT_FLIP_CW0:   begin v_next[0] = -sx; v_next[1] = sy;  v_next[2] = -sz; end
            ORIENT_FLIP_CW90:  begin v_next[0] = sy;  v_next[1] = sx;  v_next[2] = -sz; end
            ORIENT_FLIP_CW180: begin v_next[0] = sx;  v_next[1] = -sy; v_next[2] = -sz; end
            ORIENT_FLIP_CW270: begin v_next[0] = -sy; v_next[1] = -sx; v_next[2] = -sz; end
            default:           begin v_next[0] = sx;  v_next[1] = sy;  v_next[2] = sz;  end
        endcase
    end

    // d2: nine products, d3: column sums, d4: rounding
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [AW-1:0] acc_reg  [3];
    logic signed [AW-1:0] rnd_reg  [3];
    logic signed [AW-1:0] sel      [3];
    logic signed [SAMPLE_BITS-1:0] out_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            sel[j] = ang_zero_reg ? AW'(v4_reg[j]) : rnd_reg[j];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= v_next[i];
                v2_reg[i] <= v1_reg[i];
                v3_reg[i] <= v2_reg[i];
                v4_reg[i] <= v3_reg[i];
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= PW'(m_reg[i][j]) * PW'(v1_reg[i]);
            end
            for (int j = 0; j < 3; j++)
            begin
                acc_reg[j] <= AW'(prod_reg[0][j]) + AW'(prod_reg[1][j])
                              + AW'(prod_reg[2][j]);
                rnd_reg[j] <= (acc_reg[j] + (acc_reg[j][AW-1] ? A_HALF - AW'(1) : A_HALF))
                              >>> CF;
                out_reg[j] <= sat(sel[j]);
            end
        end
    end

    assign aligned.valid     = out_valid_reg;
    assign aligned.aligned_x = out_reg[0];
    assign aligned.aligned_y = out_reg[1];
    assign aligned.aligned_z = out_reg[2];

endmodule

>>> sv/sorb_checker.sv
// sorb_checker: port-level assertions for the orientation / rotation block
// bound to sensor_orientation_board_rotation_top; uses its interface ports
module sorb_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_x,
    input logic [SAMPLE_BITS-1:0] out_y,
    input logic [SAMPLE_BITS-1:0] out_z,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);
    // a stalled aligned beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z))
        else $error("aligned beat changed while stalled");

    // a stall on the aligned side holds off new samples in the same cycle
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample taken while output stalled");

    // the matrix settles after a configuration write before samples resume
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !(in_valid && in_ready))
        else $error("sample taken right after configuration write");

endmodule

bind sensor_orientation_board_rotation_top sorb_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_sorb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (aligned.valid),
    .out_ready (aligned.ready),
    .out_x     (aligned.aligned_x),
    .out_y     (aligned.aligned_y),
    .out_z     (aligned.aligned_z),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);
